[src/tclc_pkg.sv]
// Package: types, coefficients and power table for the two-channel lux calculator.
package tclc_pkg;

    localparam int POWER_TABLE_INDEX_BITS = 10;
    localparam int RATIO_FRACTION_BITS    = 16;

    localparam int COUNT_W = 16;
    localparam int CH_W    = COUNT_W + 4;
    localparam int COEF_W  = 32;
    localparam int PROD_W  = CH_W + COEF_W;
    localparam int LUX_W   = 31;
    localparam int SEG_W   = 3;
    localparam int IDX_W   = POWER_TABLE_INDEX_BITS + 1;
    localparam int Q_W     = RATIO_FRACTION_BITS;
    localparam int ROM_DEPTH = (1 << POWER_TABLE_INDEX_BITS) + 1;

    localparam logic [SEG_W-1:0] SEG_ZERO = 3'd0;
    localparam logic [SEG_W-1:0] SEG_ONE  = 3'd1;
    localparam logic [SEG_W-1:0] SEG_TWO  = 3'd2;
    localparam logic [SEG_W-1:0] SEG_THREE = 3'd3;
    localparam logic [SEG_W-1:0] SEG_FOUR = 3'd4;
    localparam logic [SEG_W-1:0] SEG_OUT  = 3'd5;

    // Q0.32 coefficients, rounded to nearest
    localparam logic [63:0] C0304 = ((64'd304 << 32) + 64'd5000) / 64'd10000;
    localparam logic [63:0] C062  = ((64'd62 << 32) + 64'd500) / 64'd1000;
    localparam logic [63:0] C0224 = ((64'd224 << 32) + 64'd5000) / 64'd10000;
    localparam logic [63:0] C031  = ((64'd31 << 32) + 64'd500) / 64'd1000;
    localparam logic [63:0] C0128 = ((64'd128 << 32) + 64'd5000) / 64'd10000;
    localparam logic [63:0] C0153 = ((64'd153 << 32) + 64'd5000) / 64'd10000;
    localparam logic [63:0] C146  = ((64'd146 << 32) + 64'd50000) / 64'd100000;
    localparam logic [63:0] C112  = ((64'd112 << 32) + 64'd50000) / 64'd100000;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    typedef struct packed {
        logic [SEG_W-1:0]   seg;
        logic [COUNT_W-1:0] full;
        logic [COUNT_W-1:0] ir;
    } item_t;

    typedef logic [COEF_W-1:0] rom_t [ROM_DEPTH];

    function automatic logic [63:0] pow5_q32(input logic [63:0] q);
        logic [63:0] q2;
        logic [63:0] q4;
        logic [63:0] p;
        q2 = (q * q) >> 32;
        q4 = (q2 * q2) >> 32;
        p  = (q4 * q) >> 32;
        return p;
    endfunction

    // (i / 2^(K+1))^1.4 in Q0.32, evaluated at elaboration
    function automatic rom_t build_rom();
        rom_t        t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] e;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            x  = 64'(i) << (32 - IDX_W);
            x2 = (x * x) >> 32;
            r  = 64'd0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (pow5_q32(c) <= x2) begin
                    r = c;
                end
            end
            e = (x * r + (64'd1 << 31)) >> 32;
            t[i] = e[COEF_W-1:0];
        end
        return t;
    endfunction

    localparam rom_t POWER_ROM = build_rom();

endpackage

[src/tclc_div.sv]
// Pipelined restoring divider: quotient bits of (ir << fraction bits) / full.
module tclc_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [tclc_pkg::COUNT_W-1:0]      dividend,
    input  logic [tclc_pkg::COUNT_W-1:0]      divisor,
    output logic [tclc_pkg::Q_W-1:0]          quotient
);
    localparam int N = tclc_pkg::Q_W;
    localparam int W = tclc_pkg::COUNT_W;

    logic [W-1:0] rem_reg [N];
    logic [W-1:0] dsr_reg [N];
    logic [N-1:0] q_reg   [N];
    logic [W-1:0] rem_next [N];
    logic [N-1:0] q_next   [N];

    // remainder starts as the dividend; valid because ir < full in segment one, the only segment that uses the quotient
    always_comb begin
        for (int s = 0; s < N; s++) begin
            logic [W:0]   two;
            logic [W-1:0] rin;
            logic [W-1:0] din;
            logic [N-1:0] qin;
            rin = (s == 0) ? dividend : rem_reg[(s == 0) ? 0 : s-1];
            din = (s == 0) ? divisor  : dsr_reg[(s == 0) ? 0 : s-1];
            qin = (s == 0) ? '0       : q_reg[(s == 0) ? 0 : s-1];
            two = {rin, 1'b0};
            if (two >= {1'b0, din}) begin
                rem_next[s] = W'(two - {1'b0, din});
                q_next[s]   = {qin[N-2:0], 1'b1};
            end else begin
                rem_next[s] = two[W-1:0];
                q_next[s]   = {qin[N-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < N; s++) begin
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
                dsr_reg[s] <= (s == 0) ? divisor : dsr_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign quotient = q_reg[N-1];

endmodule

[src/two_channel_lux_calculator.sv]
// Top level: pipelined two-channel lux calculator with stream ports.
// Pipeline: stage 0, one divider stage per ratio bit, then stages A, B, C and the output stage.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset: aresetn low clears all valid bits; payload registers are not reset.
module two_channel_lux_calculator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] full_count, [31:16] infrared_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] lux_value, [31] zero
    output logic [2:0]  m_tuser    // [2:0] segment
);
    localparam int DL = tclc_pkg::Q_W;

    logic en;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 0: classify by exact cross-multiplication
    logic [15:0] in_full;
    logic [15:0] in_ir;
    logic [2:0]  in_seg;
    assign in_full = s_tdata[15:0];
    assign in_ir   = s_tdata[31:16];

    always_comb begin
        logic [22:0] f23;
        logic [22:0] i23;
        f23 = {7'd0, in_full};
        i23 = {7'd0, in_ir};
        if (in_full == 16'd0) begin
            in_seg = tclc_pkg::SEG_OUT;
        end else if (in_ir == 16'd0) begin
            in_seg = tclc_pkg::SEG_ZERO;
        end else if ((i23 << 1) <= f23) begin
            in_seg = tclc_pkg::SEG_ONE;
        end else if (i23 * 23'd100 <= f23 * 23'd61) begin
            in_seg = tclc_pkg::SEG_TWO;
        end else if (i23 * 23'd5 <= f23 * 23'd4) begin
            in_seg = tclc_pkg::SEG_THREE;
        end else if (i23 * 23'd10 <= f23 * 23'd13) begin
            in_seg = tclc_pkg::SEG_FOUR;
        end else begin
            in_seg = tclc_pkg::SEG_OUT;
        end
    end

    tclc_pkg::item_t s0_reg;
    logic            s0_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_reg <= '{seg: in_seg, full: in_full, ir: in_ir};
        end
    end

    // divider stages, item data delayed alongside
    logic [tclc_pkg::Q_W-1:0] quot;

    tclc_div u_div (
        .aclk     (aclk),
        .en       (en),
        .dividend (s0_reg.ir),
        .divisor  (s0_reg.full),
        .quotient (quot)
    );

    tclc_pkg::item_t dl_reg [DL];
    logic [DL-1:0]   dl_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DL; s++) begin
                dl_reg[s] <= (s == 0) ? s0_reg : dl_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    // stage A: table index and registered table read
    localparam int TW = tclc_pkg::Q_W + tclc_pkg::IDX_W;
    logic [TW-1:0]                   idx_wide;
    logic [tclc_pkg::IDX_W-1:0]      idx;
    assign idx_wide = ({{tclc_pkg::IDX_W{1'b0}}, quot} << tclc_pkg::IDX_W) >> tclc_pkg::Q_W;
    assign idx = (idx_wide > TW'(tclc_pkg::ROM_DEPTH - 1))
               ? tclc_pkg::IDX_W'(tclc_pkg::ROM_DEPTH - 1) : idx_wide[tclc_pkg::IDX_W-1:0];

    logic [31:0]     ent_reg;
    tclc_pkg::item_t a_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_reg <= tclc_pkg::POWER_ROM[idx];
            a_reg   <= dl_reg[DL-1];
        end
    end

    // stage B: 0.062 * entry
    logic [63:0]     dprod_reg;
    tclc_pkg::item_t b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dprod_reg <= {32'd0, ent_reg} * {32'd0, tclc_pkg::C062[31:0]};
            b_reg     <= a_reg;
        end
    end

    // stage C: segment coefficients and the two channel products
    logic [63:0] d_full;
    logic [31:0] coef1;
    logic [31:0] coef_a;
    logic [31:0] coef_b;
    assign d_full = (dprod_reg + (64'd1 << 31)) >> 32;
    assign coef1  = (d_full >= tclc_pkg::C0304) ? 32'd0
                  : 32'(tclc_pkg::C0304 - d_full);

    always_comb begin
        case (b_reg.seg)
            tclc_pkg::SEG_ONE: begin
                coef_a = coef1;
                coef_b = 32'd0;
            end
            tclc_pkg::SEG_TWO: begin
                coef_a = tclc_pkg::C0224[31:0];
                coef_b = tclc_pkg::C031[31:0];
            end
            tclc_pkg::SEG_THREE: begin
                coef_a = tclc_pkg::C0128[31:0];
                coef_b = tclc_pkg::C0153[31:0];
            end
            tclc_pkg::SEG_FOUR: begin
                coef_a = tclc_pkg::C146[31:0];
                coef_b = tclc_pkg::C112[31:0];
            end
            default: begin
                coef_a = 32'd0;
                coef_b = 32'd0;
            end
        endcase
    end

    logic [tclc_pkg::PROD_W-1:0] pa_reg;
    logic [tclc_pkg::PROD_W-1:0] pb_reg;
    logic [2:0]                  c_seg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg    <= {12'd0, b_reg.full, 4'd0} * {20'd0, coef_a};
            pb_reg    <= {12'd0, b_reg.ir, 4'd0} * {20'd0, coef_b};
            c_seg_reg <= b_reg.seg;
        end
    end

    // output stage: rounded difference, clamped at zero, saturated at top
    logic [tclc_pkg::PROD_W-1:0] diff;
    logic [tclc_pkg::PROD_W-17:0] v;
    logic [30:0]                 lux;
    assign diff = pa_reg - pb_reg + tclc_pkg::PROD_W'(1 << 15);
    assign v    = diff[tclc_pkg::PROD_W-1:16];
    assign lux  = (pa_reg <= pb_reg) ? 31'd0
                : (v > (tclc_pkg::PROD_W-16)'(tclc_pkg::LUX_MAX)) ? tclc_pkg::LUX_MAX
                : v[30:0];

    logic [30:0] lux_reg;
    logic [2:0]  seg_reg;
    logic        a_vld_reg;
    logic        b_vld_reg;
    logic        c_vld_reg;
    logic        out_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lux_reg <= lux;
            seg_reg <= c_seg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg  <= 1'b0;
            dl_vld_reg  <= '0;
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            s0_vld_reg  <= s_tvalid;
            dl_vld_reg  <= {dl_vld_reg[DL-2:0], s0_vld_reg};
            a_vld_reg   <= dl_vld_reg[DL-1];
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            out_vld_reg <= c_vld_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, lux_reg};
    assign m_tuser  = seg_reg;

endmodule
